FILE: design/assert_macros.svh
// Assertion macros used by the search core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/btts_pkg.sv
// Shared types and constants of the BER-TLV tag search block.
package btts_pkg;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_TAG_ADDR = 3'd0;

   localparam logic [7:0] TAG_NUMBER_MASK = 8'h1F;
   localparam logic [7:0] TAG_CONSTRUCTED = 8'h20;
   localparam logic [7:0] LEN_LONG_FORM   = 8'h80;
   localparam logic [7:0] LEN_COUNT_MASK  = 8'h7F;

   typedef struct packed {
      logic        found;
      logic [15:0] value_offset;
      logic [15:0] value_length;
      logic        depth_exceeded;
   } result_type;

endpackage

FILE: design/btts_parser.sv
// Byte-wise TLV parser: header decode, level stack and search state.
module btts_parser #(
   parameter int MAX_DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 first_byte,
   input  logic [15:0]          buffer_length,
   input  logic [15:0]          target_tag,
   output logic                 res_valid,
   output btts_pkg::result_type res
);
   import btts_pkg::*;

   localparam int CW = $clog2(MAX_DEPTH + 1);
   localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   typedef enum logic [2:0] {
      PH_TAG1,
      PH_TAG2,
      PH_LEN1,
      PH_LENX,
      PH_SKIP
   } phase_type;

   logic [15:0]   pos_ff, pos_in, pos_e;
   logic [15:0]   total_ff, total_in, total_e;
   phase_type     phase_ff, phase_in, phase_e;
   logic [15:0]   tag_ff, tag_in, tag_e;
   logic [15:0]   len_ff, len_in, len_e;
   logic [6:0]    left_ff, left_in, left_e;
   logic [16:0]   skip_ff, skip_in, skip_e;
   logic [16:0]   end_ff, end_in, end_e;
   logic [CW-1:0] count_ff, count_in, count_e;
   logic          done_ff, done_in, done_e;
   logic          ovf_ff, ovf_in, ovf_e;
   logic [16:0]   stack_ff [MAX_DEPTH];

   logic          restart, zero_len, act, hit;
   phase_type     phase_dec, hdr_phase, phase_mid, phase_pop, phase_fin;
   logic [15:0]   tag_dec, len_dec, hdr_len, pos_n;
   logic [6:0]    left_dec;
   logic          hdr_fire;
   logic [16:0]   vend, hdr_skip, skip_mid, top_end;
   logic [7:0]    first_tb;
   logic          overrun, match, constructed, room, push, ovf_hit, done_fin;
   logic [CW-1:0] cnt_p, count_new;
   logic [16:0]   end_eff [MAX_DEPTH];
   logic [MAX_DEPTH-1:0] keep, top_sel;

   // Effective state: a first byte starts from the cleared state.
   assign restart  = step && first_byte;
   assign zero_len = restart && (buffer_length == 16'd0);

   always_comb begin
      if (restart) begin
         pos_e   = '0;
         total_e = buffer_length;
         phase_e = PH_TAG1;
         tag_e   = '0;
         len_e   = '0;
         left_e  = '0;
         skip_e  = '0;
         end_e   = {1'b0, buffer_length};
         count_e = '0;
         done_e  = 1'b0;
         ovf_e   = 1'b0;
      end else begin
         pos_e   = pos_ff;
         total_e = total_ff;
         phase_e = phase_ff;
         tag_e   = tag_ff;
         len_e   = len_ff;
         left_e  = left_ff;
         skip_e  = skip_ff;
         end_e   = end_ff;
         count_e = count_ff;
         done_e  = done_ff;
         ovf_e   = ovf_ff;
      end
   end

   assign act = step && !zero_len && !done_e;

   // Tag and length byte decode.
   always_comb begin
      tag_dec   = tag_e;
      len_dec   = len_e;
      left_dec  = left_e;
      phase_dec = phase_e;
      hdr_fire  = 1'b0;
      hdr_len   = '0;
      unique case (phase_e)
         PH_TAG1: begin
            tag_dec   = {8'h00, data_byte};
            phase_dec = ((data_byte & TAG_NUMBER_MASK) == TAG_NUMBER_MASK) ? PH_TAG2 : PH_LEN1;
         end
         PH_TAG2: begin
            tag_dec   = {tag_e[7:0], data_byte};
            phase_dec = PH_LEN1;
         end
         PH_LEN1: begin
            if ((data_byte & LEN_LONG_FORM) != 8'h00) begin
               left_dec = 7'(data_byte & LEN_COUNT_MASK);
               len_dec  = '0;
               if (left_dec == 7'd0) begin
                  hdr_fire = 1'b1;
               end else begin
                  phase_dec = PH_LENX;
               end
            end else begin
               hdr_fire = 1'b1;
               hdr_len  = {8'h00, data_byte};
            end
         end
         PH_LENX: begin
            len_dec  = {len_e[7:0], data_byte};
            left_dec = (left_e != 7'd0) ? left_e - 7'd1 : left_e;
            if (left_dec == 7'd0) begin
               hdr_fire = 1'b1;
               hdr_len  = len_dec;
            end
         end
         PH_SKIP: begin
         end
         default: begin
         end
      endcase
   end

   // Header complete: overrun, match, descend or skip.
   assign vend        = {1'b0, pos_e} + 17'd1 + {1'b0, hdr_len};
   assign first_tb    = (tag_e[15:8] != 8'h00) ? tag_e[15:8] : tag_e[7:0];
   assign overrun     = vend > end_e;
   assign match       = hdr_fire && !overrun && (tag_e == target_tag);
   assign constructed = (first_tb & TAG_CONSTRUCTED) != 8'h00;
   assign room        = count_e < CW'(MAX_DEPTH);
   assign push        = hdr_fire && !overrun && !match && constructed && room;
   assign ovf_hit     = hdr_fire && !overrun && !match && constructed && !room;
   assign hit         = act && match;

   always_comb begin
      hdr_phase = PH_TAG1;
      hdr_skip  = skip_e;
      if (overrun) begin
         hdr_phase = PH_SKIP;
         hdr_skip  = end_e;
      end else if (!push && (hdr_len != 16'd0)) begin
         hdr_phase = PH_SKIP;
         hdr_skip  = vend;
      end
   end

   // Close every level whose end has been reached; ends grow towards the bottom.
   assign pos_n = pos_e + 16'd1;
   assign cnt_p = count_e + CW'(push);

   always_comb begin
      count_new = '0;
      top_end   = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         end_eff[i] = (push && (count_e == CW'(i))) ? vend : stack_ff[i];
         keep[i]    = (CW'(i) < cnt_p) && (end_eff[i] > {1'b0, pos_n});
      end
      for (int i = 0; i < MAX_DEPTH; i++) begin
         top_sel[i] = keep[i] && ((i == MAX_DEPTH - 1) || !keep[(i + 1) % MAX_DEPTH]);
         count_new  = count_new + CW'(keep[i]);
         top_end    = top_end | (top_sel[i] ? end_eff[i] : 17'd0);
      end
      if (count_new == '0) begin
         top_end = {1'b0, total_e};
      end
   end

   assign phase_mid = hdr_fire ? hdr_phase : phase_dec;
   assign skip_mid  = hdr_fire ? hdr_skip : skip_e;
   assign phase_pop = (count_new != cnt_p) ? PH_TAG1 : phase_mid;
   assign phase_fin = ((phase_pop == PH_SKIP) && ({1'b0, pos_n} >= skip_mid)) ? PH_TAG1 : phase_pop;
   assign done_fin  = pos_n >= total_e;

   // Next state and result.
   always_comb begin
      pos_in    = pos_e;
      total_in  = total_e;
      phase_in  = phase_e;
      tag_in    = tag_e;
      len_in    = len_e;
      left_in   = left_e;
      skip_in   = skip_e;
      end_in    = end_e;
      count_in  = count_e;
      done_in   = done_e;
      ovf_in    = ovf_e;
      res_valid = 1'b0;
      res       = '0;
      if (zero_len) begin
         done_in   = 1'b1;
         res_valid = 1'b1;
      end else if (act) begin
         tag_in  = tag_dec;
         len_in  = hdr_fire ? hdr_len : len_dec;
         left_in = left_dec;
         skip_in = skip_mid;
         ovf_in  = ovf_e | ovf_hit;
         if (hit) begin
            done_in            = 1'b1;
            res_valid          = 1'b1;
            res.found          = 1'b1;
            res.value_offset   = pos_n;
            res.value_length   = hdr_len;
            res.depth_exceeded = ovf_e;
         end else begin
            pos_in   = pos_n;
            count_in = count_new;
            end_in   = top_end;
            phase_in = phase_fin;
            done_in  = done_fin;
            if (done_fin) begin
               res_valid          = 1'b1;
               res.depth_exceeded = ovf_e | ovf_hit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         total_ff <= '0;
         phase_ff <= PH_TAG1;
         tag_ff   <= '0;
         len_ff   <= '0;
         left_ff  <= '0;
         skip_ff  <= '0;
         end_ff   <= '0;
         count_ff <= '0;
         done_ff  <= 1'b1;
         ovf_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         skip_ff  <= skip_in;
         end_ff   <= end_in;
         count_ff <= count_in;
         done_ff  <= done_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Level ends; an entry is read only after it was pushed.
   always_ff @(posedge clock) begin
      if (act && push) begin
         stack_ff[count_e[SW-1:0]] <= vend;
      end
   end

endmodule

FILE: design/btts_rsp_skid.sv
// Two-entry result buffer: output register plus skid register.
module btts_rsp_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  btts_pkg::result_type in_res,
   output logic                 out_valid,
   input  logic                 out_ready,
   output btts_pkg::result_type out_res
);
   import btts_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop, push;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;
   assign pop       = main_valid_ff && out_ready;
   assign push      = in_valid && !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         main_valid_in = 1'b1;
         if (!main_valid_ff || pop) begin
            main_in = in_res;
         end else begin
            skid_in       = in_res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: design/ber_tlv_tag_search_core.sv
// BER-TLV tag search: scans one buffer byte per clock for a configured tag and reports
// the first match in preorder (value offset and length) or not-found at the last byte.
// Each accepted byte is parsed in the cycle it arrives; the result, if the byte causes
// one, is registered in a two-entry output buffer and is presented from there on the rsp
// channel. A new byte is taken every clock as long as the output buffer has room; the
// input stalls only when both buffer entries hold results the consumer has not taken.
// Nested constructed elements open levels on a stack of MAX_DEPTH end positions held in
// registers; deeper constructed elements are skipped and flagged with depth_exceeded.
// The target tag register sits at byte address 0 of the csr port (first tag byte high).
`include "assert_macros.svh"

module ber_tlv_tag_search_core #(
   parameter int MAX_DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Byte stream in
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] data_byte, [23:8] buffer_length
   input  logic [btts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] first_byte
   input  logic                                 req_tuser,
   // Search result out
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] value_offset, [31:16] value_length, [32] depth_exceeded, [39:33] zero
   output logic [btts_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [0] found
   output logic                                 rsp_tuser,
   // Configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [btts_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [btts_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [btts_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import btts_pkg::*;

   logic [15:0] target_ff, target_in;
   logic        csr_wr;
   logic        step;
   logic        res_valid;
   result_type  res;
   result_type  out_res;

   // Register access: zero wait states, write on the access phase.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign target_in  = (csr_wr && (csr_paddr == CSR_TARGET_TAG_ADDR)) ?
                       csr_pwdata[15:0] : target_ff;
   assign csr_prdata = (csr_paddr == CSR_TARGET_TAG_ADDR) ?
                       {16'h0000, target_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   // A byte transaction advances the parser.
   assign step = req_tvalid && req_tready;

   btts_parser #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (req_tdata[7:0]),
      .first_byte    (req_tuser),
      .buffer_length (req_tdata[23:8]),
      .target_tag    (target_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // Hold results here so the consumer can stall without losing one.
   btts_rsp_skid u_rsp_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (req_tready),
      .in_res    (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tuser = out_res.found;
   assign rsp_tdata = {7'h00, out_res.depth_exceeded, out_res.value_length,
                       out_res.value_offset};

   // A not-found transaction carries zero offset and length.
   `ASSERT_IMPLY(a_notfound_zero, clock, reset, rsp_tvalid && !rsp_tuser,
                 rsp_tdata[31:0] == 32'h0, "not-found result with nonzero offset or length")
   // The input stalls only when a result is waiting.
   `ASSERT_IMPLY(a_stall_backed, clock, reset, !req_tready, rsp_tvalid,
                 "input stalled with empty output")
   // A fresh result follows a byte transaction.
   `ASSERT_PROP(a_result_cause, clock, reset,
                (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(req_tvalid && req_tready),
                "result appeared without an input transaction")
   // A register write lands in the target tag.
   `ASSERT_PROP(a_csr_write, clock, reset,
                ($past(csr_wr && (csr_paddr == CSR_TARGET_TAG_ADDR)) && !$past(reset))
                |-> (target_ff == $past(csr_pwdata[15:0])),
                "target tag write lost")

endmodule

FILE: tb/ber_tlv_tag_search_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the BER-TLV tag search core: predicted results versus the rsp stream.
module ber_tlv_tag_search_core_test;
   import btts_pkg::*;

   localparam int TAG_LEVELS  = 8;
   // Cycles with no transaction on either stream before the run is declared hung.
   localparam int STALL_LIMIT = 4000;

   typedef logic [7:0] octets_type[$];

   typedef enum logic [2:0] {
      SCAN_TAG1,
      SCAN_TAG2,
      SCAN_LEN1,
      SCAN_LENX,
      SCAN_SKIP
   } scan_phase_type;

   // Byte-level parser of the search, plus the queue of results it has predicted.
   class tag_search_tracker;
      logic [15:0]    target;
      logic [15:0]    pos;
      logic [15:0]    buf_len;
      scan_phase_type phase;
      logic [15:0]    tag_acc;
      logic [15:0]    len_acc;
      logic [6:0]     len_left;
      logic [16:0]    skip_to;
      logic [16:0]    level_ends [TAG_LEVELS];
      int unsigned    open_levels;
      bit             idle;
      bit             deep_skip;
      result_type     pending_results[$];
      int unsigned    mismatches;

      function new();
         target      = '0;
         pos         = '0;
         buf_len     = '0;
         phase       = SCAN_TAG1;
         tag_acc     = '0;
         len_acc     = '0;
         len_left    = '0;
         skip_to     = '0;
         open_levels = 0;
         idle        = 1'b1;
         deep_skip   = 1'b0;
         mismatches  = 0;
      endfunction

      task report_mismatch(string what);
         $display("%0t ns mismatch: %s", $time, what);
         mismatches++;
      endtask

      function void add_result(bit hit, logic [15:0] off, logic [15:0] len);
         result_type r;
         r.found          = hit;
         r.value_offset   = off;
         r.value_length   = len;
         r.depth_exceeded = deep_skip;
         pending_results.push_back(r);
      endfunction

      function logic [16:0] level_end();
         if (open_levels > 0) return level_ends[open_levels - 1];
         return {1'b0, buf_len};
      endfunction

      // Header finished at position p: match, descend, or skip the value.
      function bit close_header(logic [15:0] p, logic [15:0] len);
         logic [16:0] vend;
         logic [7:0]  lead;
         vend    = {1'b0, p} + 17'd1 + {1'b0, len};
         lead    = (tag_acc[15:8] != 8'h00) ? tag_acc[15:8] : tag_acc[7:0];
         len_acc = len;
         if (vend > level_end()) begin
            // value overruns its level: abandon the level
            phase   = SCAN_SKIP;
            skip_to = level_end();
            return 1'b0;
         end
         if (tag_acc == target) return 1'b1;
         if ((lead & TAG_CONSTRUCTED) != 8'h00) begin
            if (open_levels < TAG_LEVELS) begin
               level_ends[open_levels] = vend;
               open_levels++;
               phase = SCAN_TAG1;
               return 1'b0;
            end
            deep_skip = 1'b1;
         end
         if (len == 16'h0000) begin
            phase = SCAN_TAG1;
         end else begin
            phase   = SCAN_SKIP;
            skip_to = vend;
         end
         return 1'b0;
      endfunction

      // Note one accepted byte; returns 1 unless the byte is ignored.
      function bit take_byte(logic [7:0] b, logic first, logic [15:0] blen);
         logic [15:0] p;
         bit          hit;
         hit = 1'b0;
         if (first) begin
            buf_len     = blen;
            pos         = '0;
            phase       = SCAN_TAG1;
            tag_acc     = '0;
            len_acc     = '0;
            len_left    = '0;
            skip_to     = '0;
            open_levels = 0;
            idle        = 1'b0;
            deep_skip   = 1'b0;
            if (blen == 16'h0000) begin
               idle = 1'b1;
               add_result(1'b0, 16'h0000, 16'h0000);
               return 1'b1;
            end
         end
         if (idle) return 1'b0;
         p = pos;
         case (phase)
            SCAN_TAG1: begin
               tag_acc = {8'h00, b};
               phase   = ((b & TAG_NUMBER_MASK) == TAG_NUMBER_MASK) ? SCAN_TAG2 : SCAN_LEN1;
            end
            SCAN_TAG2: begin
               tag_acc = {tag_acc[7:0], b};
               phase   = SCAN_LEN1;
            end
            SCAN_LEN1: begin
               if ((b & LEN_LONG_FORM) != 8'h00) begin
                  len_left = b[6:0];
                  len_acc  = '0;
                  if (len_left == 7'd0) hit = close_header(p, 16'h0000);
                  else phase = SCAN_LENX;
               end else begin
                  hit = close_header(p, {8'h00, b});
               end
            end
            SCAN_LENX: begin
               len_acc = {len_acc[7:0], b};
               if (len_left != 7'd0) len_left--;
               if (len_left == 7'd0) hit = close_header(p, len_acc);
            end
            default: ;
         endcase
         if (hit) begin
            idle = 1'b1;
            add_result(1'b1, p + 16'd1, len_acc);
            return 1'b1;
         end
         pos = p + 16'd1;
         while (open_levels > 0 && {1'b0, pos} >= level_end()) begin
            open_levels--;
            phase = SCAN_TAG1;
         end
         if (phase == SCAN_SKIP && {1'b0, pos} >= skip_to) phase = SCAN_TAG1;
         if (pos >= buf_len) begin
            idle = 1'b1;
            add_result(1'b0, 16'h0000, 16'h0000);
         end
         return 1'b1;
      endfunction

      task check_result(logic found, logic [15:0] off, logic [15:0] len, logic deep);
         result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result arrived with none pending");
            return;
         end
         want = pending_results.pop_front();
         if (found !== want.found)
            report_mismatch($sformatf("found %0b, predicted %0b", found, want.found));
         if (off !== want.value_offset)
            report_mismatch($sformatf("value_offset %0d, predicted %0d", off, want.value_offset));
         if (len !== want.value_length)
            report_mismatch($sformatf("value_length %0d, predicted %0d", len, want.value_length));
         if (deep !== want.depth_exceeded)
            report_mismatch($sformatf("depth_exceeded %0b, predicted %0b", deep,
                                      want.depth_exceeded));
      endtask
   endclass

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_tvalid   = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata    = '0;
   logic                   req_tuser    = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready   = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_psel     = 1'b0;
   logic                   csr_penable  = 1'b0;
   logic                   csr_pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr    = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata   = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   tag_search_tracker tracker = new();

   logic [15:0] target_now    = 16'h0000;  // tag the frame builder aims at
   int          req_gap_pct   = 0;
   int          rsp_stall_pct = 0;
   int          rsp_hold      = 0;
   int          stall_cycles  = 0;
   int unsigned items_sent    = 0;

   ber_tlv_tag_search_core #(
      .MAX_DEPTH(TAG_LEVELS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #2 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 2) : $urandom_range(5, 30);
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 10;
         2:       return 30;
         default: return 60;
      endcase
   endfunction

   // Consumer side: hold rsp_tready low for random stretches.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   = rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_hold   = gap_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check every result transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[32]);
   end

   // Watchdog: give up when neither stream has moved for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic octets_type encode_tag(bit constr, bit aim);
      octets_type q;
      logic [7:0] lead;
      if (aim) begin
         if (target_now[15:8] != 8'h00) q.push_back(target_now[15:8]);
         q.push_back(target_now[7:0]);
         return q;
      end
      lead    = 8'($urandom_range(0, 255));
      lead[5] = constr;
      if ($urandom_range(0, 9) < 3) begin
         lead[4:0] = 5'h1F;
         q.push_back(lead);
         q.push_back(8'($urandom_range(0, 255)));
      end else begin
         if (lead[4:0] == 5'h1F) lead[0] = 1'b0;
         q.push_back(lead);
      end
      return q;
   endfunction

   // Mostly short form below 128, else long form, sometimes padded with leading zeros.
   function automatic octets_type encode_len(int unsigned len);
      octets_type  q;
      logic [15:0] l16;
      int          n;
      int          pad;
      l16 = 16'(len);
      if (len < 128 && $urandom_range(0, 3) != 0) begin
         q.push_back(l16[7:0]);
         return q;
      end
      n   = (len == 0) ? 0 : ((len < 256) ? 1 : 2);
      pad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
      if ($urandom_range(0, 60) == 0) pad = 127 - n;
      q.push_back(LEN_LONG_FORM | 8'(n + pad));
      repeat (pad) q.push_back(8'h00);
      if (n == 2) q.push_back(l16[15:8]);
      if (n >= 1) q.push_back(l16[7:0]);
      return q;
   endfunction

   // One element; below 'chain' levels it is forced constructed to build deep nests, unless it carries the target tag.
   function automatic octets_type make_elem(int lvl, int chain);
      octets_type body;
      octets_type hdr;
      octets_type kid;
      logic [7:0] tlead;
      bit         aim;
      bit         constr;
      int         n;
      aim   = ($urandom_range(0, 99) < 12);
      tlead = (target_now[15:8] != 8'h00) ? target_now[15:8] : target_now[7:0];
      if (aim) constr = tlead[5];
      else constr = (lvl < chain) || (lvl < 4 && $urandom_range(0, 2) == 0);
      if (constr) begin
         n = (lvl < chain) ? 1 : $urandom_range(0, 3);
         repeat (n) begin
            kid = make_elem(lvl + 1, chain);
            foreach (kid[i]) body.push_back(kid[i]);
         end
      end else begin
         n = ($urandom_range(0, 30) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 5);
         repeat (n) body.push_back(8'($urandom_range(0, 255)));
      end
      hdr = encode_tag(constr, aim);
      kid = encode_len(body.size());
      foreach (kid[i]) hdr.push_back(kid[i]);
      foreach (body[i]) hdr.push_back(body[i]);
      return hdr;
   endfunction

   function automatic logic [15:0] pick_target();
      logic [15:0] t;
      logic [7:0]  r;
      r = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: begin
            t = {8'h00, r};
            if (t[4:0] == 5'h1F) t[0] = 1'b0;
         end
         1: t = {r | TAG_NUMBER_MASK, 8'($urandom_range(0, 255))};
         2: t = 16'($urandom_range(0, 65535));
         default: begin
            t = {8'h00, r | TAG_CONSTRUCTED};
            if (t[4:0] == 5'h1F) t[0] = 1'b0;
         end
      endcase
      return t;
   endfunction

   // Drive one byte and hold it until the transaction completes.
   task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] blen);
      int gap;
      if ($urandom_range(0, 99) < req_gap_pct) begin
         gap = gap_len();
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blen, b};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      if (tracker.take_byte(b, first, blen)) items_sent++;
   endtask

   task automatic send_bytes(input octets_type q, input logic [15:0] blen);
      foreach (q[i]) send_byte(q[i], i == 0, blen);
   endtask

   // Drop valid, wait for every predicted result, then let the pipeline empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_target(input logic [15:0] t);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_TARGET_TAG_ADDR;
      csr_pwdata  <= {16'h0000, t};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.target = t;
      target_now     = t;
   endtask

   // Mostly well-formed buffers; the rest truncated, corrupted, overlong, cut short, empty or noise.
   task automatic send_random_frame();
      octets_type  frame;
      octets_type  kid;
      int          chain;
      int          mode;
      int          cut;
      logic [15:0] blen;
      chain = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 11) : 0;
      repeat ($urandom_range(1, 3)) begin
         kid = make_elem(0, chain);
         foreach (kid[i]) frame.push_back(kid[i]);
         chain = 0;
      end
      blen = 16'(frame.size());
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
         frame.delete();
         repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom_range(0, 255)));
         blen = 16'(frame.size());
      end else if (mode < 18) begin
         blen = 16'($urandom_range(1, frame.size()));
      end else if (mode < 26) begin
         frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (mode < 33) begin
         // buffer claims more bytes than arrive: the next first byte restarts
         blen = 16'($urandom_range(frame.size() + 1, 65535));
      end else if (mode < 40) begin
         cut = $urandom_range(1, frame.size());
         while (frame.size() > cut) void'(frame.pop_back());
      end else if (mode < 43) begin
         blen = 16'h0000;
      end
      // stray bytes after the buffer should be ignored
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(0, 255)));
      send_bytes(frame, blen);
   endtask

   initial begin
      octets_type  seq;
      int          phase_no;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed buffers against a one-byte primitive tag.
      write_target(16'h005A);
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      seq = '{8'h33};                        // zero buffer length
      send_bytes(seq, 16'd0);
      seq = '{8'h5A, 8'h80, 8'h00};          // long form with no count, then an idle byte
      send_bytes(seq, 16'd2);
      seq = '{8'h01, 8'h05};                 // abandoned by the next first byte
      send_bytes(seq, 16'd10);
      seq = '{8'h04, 8'h09, 8'h00, 8'h00, 8'h00};   // value overruns the buffer
      send_bytes(seq, 16'd5);
      seq = '{8'h01, 8'h00, 8'h1F};          // two-byte tag cut off by the end
      send_bytes(seq, 16'd3);
      seq = '{8'h7F, 8'h22, 8'h82, 8'h00, 8'h03, 8'h5A, 8'h01, 8'hEE};   // nested match
      send_bytes(seq, 16'd8);
      settle();

      // Random phases, each with its own target tag and idling profile.
      phase_no = 0;
      while (items_sent < 700) begin
         case (phase_no)
            0:       write_target(16'h0000);
            1:       write_target(16'hFFFF);
            default: write_target(pick_target());
         endcase
         if (phase_no % 4 == 3) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = pick_pct();
            rsp_stall_pct = pick_pct();
         end
         repeat ($urandom_range(3, 6)) send_random_frame();
         settle();
         phase_no++;
      end

      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
